FILE: rtl/core/positional_list_store_assert.svh
// Assertion macros used by the list store control module.
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// Checks a property at every rising clock edge outside of reset.
`define PLS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checks that a condition implies another one in the following cycle.
`define PLS_ASSERT_NEXT(label, cond, prop, msg) \
  `PLS_ASSERT(label, (cond) |=> (prop), msg)

`endif

FILE: rtl/core/pls_pkg.sv
package pls_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int VALUE_W     = 32;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int COUNT_W     = $clog2(MAX_ENTRIES + 1);
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 3;

  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
  localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADPOS   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd4;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [ADDR_W-1:0]   found;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic                full;
    logic [VALUE_W-1:0]  first;
    logic [VALUE_W-1:0]  last;
  } result_t;

endpackage

FILE: rtl/core/positional_list_store.sv
// Ordered list of up to sixteen 32-bit entries kept in a RAM with one read
// and one write port.
// An item is accepted at a rising edge where start is high and busy is low.
// Its command inserts, removes, gets, searches for a value or clears.
// Exactly one result follows per item: done is high for one cycle and the
// result ports hold status, data, index found, count, flags and the first
// and last entries during that cycle. The receiver cannot stall the result.
// The RAM has one read port with a registered read, and each moved or
// compared entry passes through a read state and then a write or compare
// state. Insert moves the entries from the tail down to position p up by
// one and then writes the value; get and remove read the entry at the
// position, and remove then moves the later entries down by one. Busy
// stays high until done is shown, so the next item is taken at the edge
// that ends the done cycle.
// cfg_we writes the capacity in use from cfg_wdata; 0 acts as 1 and values
// above sixteen act as sixteen. Write it only while idle.
// Synchronous reset empties the list and sets the capacity to sixteen.
module positional_list_store (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [pls_pkg::CMD_W-1:0]         command,
  input  logic [pls_pkg::COUNT_W-1:0]       position,
  input  logic [pls_pkg::VALUE_W-1:0]       element_value,
  input  logic                              cfg_we,
  input  logic [pls_pkg::COUNT_W-1:0]       cfg_wdata,
  output logic                              done,
  output logic [pls_pkg::STATUS_W-1:0]      status,
  output logic [pls_pkg::VALUE_W-1:0]       data_out,
  output logic [pls_pkg::ADDR_W-1:0]        found_index,
  output logic [pls_pkg::COUNT_W-1:0]       entry_count,
  output logic                              is_empty,
  output logic                              is_full,
  output logic [pls_pkg::VALUE_W-1:0]       first_value,
  output logic [pls_pkg::VALUE_W-1:0]       last_value
);

  logic [pls_pkg::COUNT_W-1:0] cap_reg;
  logic [pls_pkg::COUNT_W-1:0] cap_eff;
  pls_pkg::result_t            result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= pls_pkg::COUNT_W'(pls_pkg::MAX_ENTRIES);
    end else if (cfg_we) begin
      cap_reg <= cfg_wdata;
    end
  end

  always_comb begin
    cap_eff = cap_reg;
    if (cap_reg == '0) begin
      cap_eff = pls_pkg::COUNT_W'(1);
    end else if (cap_reg > pls_pkg::COUNT_W'(pls_pkg::MAX_ENTRIES)) begin
      cap_eff = pls_pkg::COUNT_W'(pls_pkg::MAX_ENTRIES);
    end
  end

  pls_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .command      (command),
    .position     (position),
    .element_value(element_value),
    .cap          (cap_eff),
    .busy         (busy),
    .done         (done),
    .result       (result)
  );

  assign status      = result.status;
  assign data_out    = result.data;
  assign found_index = result.found;
  assign entry_count = result.count;
  assign is_empty    = result.empty;
  assign is_full     = result.full;
  assign first_value = result.first;
  assign last_value  = result.last;

endmodule

FILE: rtl/core/pls_ram.sv
module pls_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pls_ctrl.sv
`include "positional_list_store_assert.svh"

module pls_ctrl (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [pls_pkg::CMD_W-1:0]        command,
  input  logic [pls_pkg::COUNT_W-1:0]      position,
  input  logic [pls_pkg::VALUE_W-1:0]      element_value,
  input  logic [pls_pkg::COUNT_W-1:0]      cap,
  output logic                             busy,
  output logic                             done,
  output pls_pkg::result_t                 result
);

  typedef enum logic [3:0] {
    S_IDLE, S_SH_RD, S_SH_WR, S_PUT, S_RD_POS, S_RD_DATA, S_RM_RD, S_RM_WR,
    S_SR_RD, S_SR_CMP, S_FIRST, S_LAST, S_TAIL
  } state_t;

  state_t                          state;
  logic [pls_pkg::CMD_W-1:0]       cmd_q;
  logic [pls_pkg::COUNT_W-1:0]     pos_q;
  logic [pls_pkg::VALUE_W-1:0]     val_q;
  logic [pls_pkg::COUNT_W-1:0]     count;
  logic [pls_pkg::ADDR_W-1:0]      idx;
  logic [pls_pkg::ADDR_W-1:0]      idx_dn;
  logic [pls_pkg::ADDR_W-1:0]      idx_up;
  logic [pls_pkg::COUNT_W-1:0]     count_m1;

  logic                            ram_we;
  logic [pls_pkg::ADDR_W-1:0]      ram_waddr;
  logic [pls_pkg::VALUE_W-1:0]     ram_wdata;
  logic [pls_pkg::ADDR_W-1:0]      ram_raddr;
  logic [pls_pkg::VALUE_W-1:0]     ram_rdata;

  assign idx_dn   = idx - 1'b1;
  assign idx_up   = idx + 1'b1;
  assign count_m1 = count - 1'b1;
  assign busy     = (state != S_IDLE);

  pls_ram #(
    .DEPTH(pls_pkg::MAX_ENTRIES),
    .WIDTH(pls_pkg::VALUE_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx;
    ram_wdata = ram_rdata;
    ram_raddr = '0;
    case (state)
      S_SH_RD: begin
        ram_raddr = idx_dn;
      end
      S_SH_WR, S_RM_WR: begin
        ram_we = 1'b1;
      end
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[pls_pkg::ADDR_W-1:0];
        ram_wdata = val_q;
      end
      S_RD_POS: begin
        ram_raddr = pos_q[pls_pkg::ADDR_W-1:0];
      end
      S_RM_RD: begin
        ram_raddr = idx_up;
      end
      S_SR_RD: begin
        ram_raddr = idx;
      end
      S_LAST: begin
        ram_raddr = count_m1[pls_pkg::ADDR_W-1:0];
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_q         <= command;
            pos_q         <= position;
            val_q         <= element_value;
            result.status <= pls_pkg::ST_OK;
            result.data   <= '0;
            result.found  <= '0;
            state         <= S_FIRST;
            case (command)
              pls_pkg::CMD_INSERT: begin
                if (position > count) begin
                  result.status <= pls_pkg::ST_BADPOS;
                end else if (count >= cap) begin
                  result.status <= pls_pkg::ST_FULL;
                end else begin
                  idx   <= count[pls_pkg::ADDR_W-1:0];
                  state <= (count > position) ? S_SH_RD : S_PUT;
                end
              end
              pls_pkg::CMD_REMOVE, pls_pkg::CMD_GET: begin
                if (position > count) begin
                  result.status <= pls_pkg::ST_BADPOS;
                end else if (count == '0) begin
                  result.status <= pls_pkg::ST_EMPTY;
                end else if (position == count) begin
                  result.status <= pls_pkg::ST_BADPOS;
                end else begin
                  state <= S_RD_POS;
                end
              end
              pls_pkg::CMD_SEARCH: begin
                result.status <= pls_pkg::ST_NOTFOUND;
                idx           <= '0;
                if (element_value != '0 && count != '0) begin
                  state <= S_SR_RD;
                end
              end
              pls_pkg::CMD_CLEAR: begin
                count <= '0;
              end
              default: begin
                state <= S_FIRST;
              end
            endcase
          end
        end
        S_SH_RD: begin
          state <= S_SH_WR;
        end
        S_SH_WR: begin
          idx   <= idx_dn;
          state <= (pls_pkg::COUNT_W'(idx_dn) > pos_q) ? S_SH_RD : S_PUT;
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_FIRST;
        end
        S_RD_POS: begin
          state <= S_RD_DATA;
        end
        S_RD_DATA: begin
          result.data <= ram_rdata;
          state       <= S_FIRST;
          if (cmd_q == pls_pkg::CMD_REMOVE) begin
            count <= count_m1;
            idx   <= pos_q[pls_pkg::ADDR_W-1:0];
            if (pos_q < count_m1) begin
              state <= S_RM_RD;
            end
          end
        end
        S_RM_RD: begin
          state <= S_RM_WR;
        end
        S_RM_WR: begin
          idx   <= idx_up;
          state <= (pls_pkg::COUNT_W'(idx_up) < count) ? S_RM_RD : S_FIRST;
        end
        S_SR_RD: begin
          state <= S_SR_CMP;
        end
        S_SR_CMP: begin
          if (ram_rdata == val_q) begin
            result.status <= pls_pkg::ST_OK;
            result.found  <= idx;
            state         <= S_FIRST;
          end else if (pls_pkg::COUNT_W'(idx) + 1'b1 < count) begin
            idx   <= idx_up;
            state <= S_SR_RD;
          end else begin
            state <= S_FIRST;
          end
        end
        S_FIRST: begin
          result.count <= count;
          result.empty <= (count == '0);
          result.full  <= (count >= cap);
          if (count == '0) begin
            result.first <= '0;
            result.last  <= '0;
            done         <= 1'b1;
            state        <= S_IDLE;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          result.first <= ram_rdata;
          state        <= S_TAIL;
        end
        S_TAIL: begin
          result.last <= ram_rdata;
          done        <= 1'b1;
          state       <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PLS_ASSERT(a_done_idle, done |-> !busy, "result strobe while still busy")
  `PLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not start work")
  `PLS_ASSERT(a_done_after_work, done |-> $past(busy), "result strobe without work")
  `PLS_ASSERT(a_count_max, count <= pls_pkg::COUNT_W'(pls_pkg::MAX_ENTRIES), "count overflow")

endmodule
